@@ src/lisr_pkg.sv @@
// package with constants and types of the linear interpolation resampler
`timescale 1ns / 1ps
package lisr_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP     = 2'd0,
    CFG_OUT_MONO = 2'd1,
    CFG_SRC_MONO = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEFT,
    ST_RIGHT,
    ST_EMIT
  } state_e;

endpackage

@@ src/lisr_if.sv @@
// stream interfaces for source frames and resampled frames
`timescale 1ns / 1ps
interface lisr_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface lisr_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          last_of_run;

  modport source (output valid, output out_left, output out_right, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input last_of_run,
                  output ready);
endinterface

@@ src/linear_interp_stereo_resampler_unit.sv @@
// top level of the linear interpolation stereo resampler
//
//  channel | dir | handshake           | payload
//  in_i    | in  | in_i.valid/ready    | in_left, in_right
//  out_o   | out | out_o.valid/ready   | out_left, out_right, last_of_run
//  cfg     | in  | cfg_we_i            | cfg_idx_i, cfg_data_i
//
//  an item that causes no result leaves the block idle
//  each result passes three steps: left product, right product, emit; one multiplier
//  is shared by both channels, and the block takes no new item until its run ends
//  reset clears phase, previous frame, mono flags and output valid, sets step to 1.0; no clearing pass
//  a full output register stalls the emit step until out_o.ready
`timescale 1ns / 1ps
module linear_interp_stereo_resampler_unit
  import lisr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lisr_in_if.sink                in_i,
  lisr_out_if.source             out_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [FRAC_BITS+2:0]   cfg_data_i
);

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned FW = FRAC_BITS;
  localparam int unsigned PW = FW + 4;
  localparam int unsigned TW = FW + 3;
  localparam int unsigned MW = SW + FW + 2;
  localparam logic [TW-1:0] STEP_MIN  = TW'(1) << (FW - 6);
  localparam logic [TW-1:0] STEP_RST  = TW'(1) << FW;
  localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FW;

  state_e state_q, state_d;

  logic [TW-1:0]        step_q;
  logic                 out_mono_q, src_mono_q;
  logic [PW-1:0]        phase_q, phase_d;
  logic                 have_prev_q;
  logic signed [SW-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic signed [SW-1:0] lerp_l_q, lerp_r_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_l_q, out_r_q;
  logic                 out_last_q;

  logic                 accept;
  logic signed [SW-1:0] in_r_eff;
  logic                 phase_ge_one;
  logic [TW-1:0]        step_eff;
  logic [PW-1:0]        phase_sum;
  logic                 run_end;
  logic                 out_load;
  logic                 sel_right;
  logic signed [SW-1:0] mul_base, mul_cur;
  logic signed [SW:0]   mul_diff;
  logic signed [MW-1:0] mul_prod;
  logic signed [SW:0]   lerp_sum;
  logic signed [SW-1:0] lerp_res;
  logic signed [SW:0]   mix_sum;
  logic signed [SW-1:0] emit_l, emit_r;

  assign accept       = in_i.valid && in_i.ready;
  assign in_r_eff     = src_mono_q ? in_i.in_left : in_i.in_right;
  assign phase_ge_one = |phase_q[PW-1:FW];
  assign step_eff     = (step_q < STEP_MIN) ? STEP_MIN : step_q;
  assign phase_sum    = phase_q + {1'b0, step_eff};
  assign run_end      = |phase_sum[PW-1:FW];
  assign out_load     = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // shared interpolation unit
  assign mul_base = sel_right ? prev_r_q : prev_l_q;
  assign mul_cur  = sel_right ? cur_r_q : cur_l_q;
  assign mul_diff = {mul_cur[SW-1], mul_cur} - {mul_base[SW-1], mul_base};
  assign mul_prod = MW'(mul_diff) * $signed({1'b0, phase_q[FW-1:0]});
  assign lerp_sum = {mul_base[SW-1], mul_base} + mul_prod[FW+SW:FW];
  assign lerp_res = lerp_sum[SW-1:0];

  // mono mix
  assign mix_sum = {lerp_l_q[SW-1], lerp_l_q} + {lerp_r_q[SW-1], lerp_r_q};
  assign emit_l  = out_mono_q ? mix_sum[SW:1] : lerp_l_q;
  assign emit_r  = out_mono_q ? mix_sum[SW:1] : lerp_r_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && have_prev_q && !phase_ge_one) begin
          state_d = ST_LEFT;
        end
      end
      ST_LEFT:  state_d = ST_RIGHT;
      ST_RIGHT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_d = run_end ? ST_IDLE : ST_LEFT;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    sel_right  = (state_q == ST_RIGHT);
    phase_d    = phase_q;
    if (accept && have_prev_q && phase_ge_one) begin
      phase_d = phase_q - PHASE_ONE;
    end else if (out_load) begin
      phase_d = run_end ? (phase_sum - PHASE_ONE) : phase_sum;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_left    = out_l_q;
  assign out_o.out_right   = out_r_q;
  assign out_o.last_of_run = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_RST;
      out_mono_q  <= 1'b0;
      src_mono_q  <= 1'b0;
      phase_q     <= '0;
      have_prev_q <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STEP:     step_q     <= cfg_data_i;
          CFG_OUT_MONO: out_mono_q <= cfg_data_i[0];
          CFG_SRC_MONO: src_mono_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        have_prev_q <= 1'b1;
        if (!have_prev_q || phase_ge_one) begin
          prev_l_q <= in_i.in_left;
          prev_r_q <= in_r_eff;
        end
      end else if (out_load && run_end) begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_l_q <= in_i.in_left;
      cur_r_q <= in_r_eff;
    end
    if (state_q == ST_LEFT) begin
      lerp_l_q <= lerp_res;
    end
    if (state_q == ST_RIGHT) begin
      lerp_r_q <= lerp_res;
    end
    if (out_load) begin
      out_l_q    <= emit_l;
      out_r_q    <= emit_r;
      out_last_q <= run_end;
    end
  end

endmodule

@@ tb/sv/linear_interp_stereo_resampler_unit_tb.sv @@
// testbench of the linear interpolation stereo resampler with a frame-accurate scoreboard
`timescale 1ns / 1ps
module linear_interp_stereo_resampler_unit_tb;
  import lisr_pkg::*;

  localparam int unsigned SW      = SAMPLE_BITS_DEF;
  localparam int unsigned FW      = FRAC_BITS_DEF;
  localparam int unsigned STEP_W  = FW + 3;
  localparam int unsigned PHASE_W = FW + 4;
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  localparam logic [PHASE_W-1:0]   ONE_PHASE = PHASE_W'(1) << FW;
  localparam logic [STEP_W-1:0]    STEP_MIN  = STEP_W'(1) << (FW - 6);
  localparam logic [STEP_W-1:0]    STEP_MAX  = '1;
  localparam logic [STEP_W-1:0]    STEP_3Q   = STEP_W'(3) << (FW - 2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_ZERO = '0;
  localparam logic signed [SW-1:0] S_NEG1 = '1;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } out_frame_t;

  class resample_checker;
    logic [STEP_W-1:0]    step;
    bit                   out_mono;
    bit                   src_mono;
    logic signed [SW-1:0] prev_l;
    logic signed [SW-1:0] prev_r;
    logic [PHASE_W-1:0]   phase;
    bit                   have_prev;
    out_frame_t           expected_frames[$];
    int                   errors;
    int                   frames_taken;
    int                   results_checked;

    function new();
      step = ONE_PHASE[STEP_W-1:0];
      out_mono = 1'b0;
      src_mono = 1'b0;
      prev_l = '0;
      prev_r = '0;
      phase = '0;
      have_prev = 1'b0;
      errors = 0;
      frames_taken = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
      case (idx)
        CFG_STEP:     step = data;
        CFG_OUT_MONO: out_mono = data[0];
        CFG_SRC_MONO: src_mono = data[0];
        default: ;
      endcase
    endfunction

    function logic signed [SW-1:0] interp(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                                          logic [FW-1:0] frac);
      longint diff;
      longint res;
      diff = longint'(b) - longint'(a);
      res = longint'(a) + ((diff * longint'(frac)) >>> FW);
      return res[SW-1:0];
    endfunction

    function void take_frame(logic signed [SW-1:0] in_l, logic signed [SW-1:0] in_r);
      logic signed [SW-1:0] cur_l;
      logic signed [SW-1:0] cur_r;
      logic signed [SW-1:0] l;
      logic signed [SW-1:0] r;
      logic signed [SW:0]   mix;
      logic [STEP_W-1:0]    st;
      int                   n;
      out_frame_t           f;
      frames_taken++;
      cur_l = in_l;
      cur_r = src_mono ? in_l : in_r;
      st = (step < STEP_MIN) ? STEP_MIN : step;
      n = 0;
      if (have_prev) begin
        while (phase < ONE_PHASE && n < MAX_RUN) begin
          l = interp(prev_l, cur_l, phase[FW-1:0]);
          r = interp(prev_r, cur_r, phase[FW-1:0]);
          if (out_mono) begin
            mix = {l[SW-1], l} + {r[SW-1], r};
            l = mix[SW:1];
            r = l;
          end
          f.left = l;
          f.right = r;
          f.last = 1'b0;
          expected_frames.push_back(f);
          n++;
          phase = phase + PHASE_W'(st);
        end
        if (n > 0) expected_frames[expected_frames.size()-1].last = 1'b1;
        phase = phase - ONE_PHASE;
      end
      prev_l = cur_l;
      prev_r = cur_r;
      have_prev = 1'b1;
    endfunction

    function void check_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic last);
      out_frame_t exp_f;
      if (expected_frames.size() == 0) begin
        $error("unexpected result: out_left %0d out_right %0d last_of_run %0b", l, r, last);
        errors++;
        return;
      end
      exp_f = expected_frames.pop_front();
      results_checked++;
      if (l !== exp_f.left) begin
        $error("out_left: expected %0d, got %0d", exp_f.left, l);
        errors++;
      end
      if (r !== exp_f.right) begin
        $error("out_right: expected %0d, got %0d", exp_f.right, r);
        errors++;
      end
      if (last !== exp_f.last) begin
        $error("last_of_run: expected %0b, got %0b", exp_f.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [STEP_W-1:0]    cfg_data_i;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold;
  int unsigned cycle_count;
  int          settings_used;

  resample_checker chk;

  lisr_in_if  #(.SAMPLE_BITS(SW)) src_ch ();
  lisr_out_if #(.SAMPLE_BITS(SW)) res_ch ();

  linear_interp_stereo_resampler_unit #(
    .SAMPLE_BITS(SW),
    .FRAC_BITS  (FW)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (src_ch),
    .out_o     (res_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    res_ch.ready = 1'b0;
    rx_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) chk.write_reg(cfg_idx_i, cfg_data_i);
      if (src_ch.valid && src_ch.ready) chk.take_frame(src_ch.in_left, src_ch.in_right);
      if (res_ch.valid && res_ch.ready) begin
        chk.check_frame(res_ch.out_left, res_ch.out_right, res_ch.last_of_run);
      end
    end
  end

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return S_ZERO;
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      src_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    src_ch.valid    <= 1'b1;
    src_ch.in_left  <= l;
    src_ch.in_right <= r;
    do @(posedge clk_i); while (!(src_ch.valid && src_ch.ready));
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block idle: nothing outstanding and time for items that cause no result
  task automatic settle();
    @(negedge clk_i);
    src_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [STEP_W-1:0] step, input bit omono, input bit smono);
    logic [STEP_W-1:0] d;
    settle();
    set_reg(CFG_STEP, step);
    d = STEP_W'($urandom);
    d[0] = omono;
    set_reg(CFG_OUT_MONO, d);
    d = STEP_W'($urandom);
    d[0] = smono;
    set_reg(CFG_SRC_MONO, d);
    settings_used++;
  endtask

  task automatic random_phase(input int n, input logic [STEP_W-1:0] step, input bit omono,
                              input bit smono, input int unsigned hold);
    configure(step, omono, smono);
    rx_hold = hold;
    repeat (n) send_frame(pick_sample(), pick_sample());
  endtask

  initial begin
    chk = new();
    settings_used = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_STEP;
    cfg_data_i = '0;
    src_ch.valid = 1'b0;
    src_ch.in_left = '0;
    src_ch.in_right = '0;
    tx_idle_pct = 10;
    rx_idle_pct = 71;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, first item only stored
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_ZERO, S_NEG1);
    settle();

    // spare index ignored, zero step runs at the floor
    set_reg(CFG_IDX_SPARE, '1);
    set_reg(CFG_STEP, '0);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);

    // largest step: phase often starts at or above one
    configure(STEP_MAX, 1'b1, 1'b0);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MIN);
    send_frame(S_MAX, S_MAX);
    send_frame(S_NEG1, S_ZERO);
    send_frame(S_ZERO, S_NEG1);
    send_frame(S_MIN, S_MAX);

    configure(STEP_MIN - 1'b1, 1'b0, 1'b1);
    send_frame(S_MIN, SW'(1234));
    send_frame(S_MAX, SW'(-5));

    configure(STEP_3Q, 1'b1, 1'b0);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    send_frame(S_NEG1, S_MAX);
    send_frame(S_ZERO, S_MIN);

    random_phase(20, STEP_W'($urandom_range(98304, 32768)), 1'b0, 1'b0, 0);
    // receiver holds off so the block fills and stalls its input
    random_phase(4, STEP_MIN, 1'b1, 1'b0, 400);

    tx_idle_pct = 71;
    rx_idle_pct = 10;
    random_phase(20, STEP_MAX, 1'b0, 1'b1, 0);
    random_phase(20, STEP_W'($urandom_range(262143, 16384)), 1'($urandom),
                 1'($urandom), 0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(3, STEP_W'($urandom_range(STEP_MIN - 1, 0)), 1'($urandom),
                 1'($urandom), 0);
    random_phase(24, STEP_W'($urandom_range(STEP_MAX, 8192)), 1'($urandom),
                 1'($urandom), 0);
    settle();

    $display("summary: %0d source items, %0d resampled items checked, %0d register settings",
             chk.frames_taken, chk.results_checked, settings_used);
    $display("summary: steps from below the 1/64 floor to the top, mono and stereo both sides");
    if (chk.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
